// ----- src/mba_pkg.sv -----
// Shared constants for the masked bitsliced adder.
// No dependencies; imported by every module of the block.
package mba_pkg;

  // Width of every word field on the ports.
  localparam int unsigned FIELD_W = 32;

  // Configuration port layout.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 5;
  localparam int unsigned NUM_BITS_W = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_BITS      = 2'd0,
    CFG_CARRY_OUT_ENA = 2'd1
  } cfg_reg_t;

  // Number of results a single slice may produce.
  localparam int unsigned MAX_RESULTS = 2;

endpackage

// ----- src/mba_slice.sv -----
// One bit slice of the two-share masked ripple-carry adder with its PINI AND.
// Depends on mba_pkg.
module mba_slice import mba_pkg::*; #(
  parameter int unsigned LW = 32
) (
  input  logic          first,
  input  logic [LW-1:0] a0,
  input  logic [LW-1:0] a1,
  input  logic [LW-1:0] b0,
  input  logic [LW-1:0] b1,
  input  logic [LW-1:0] rnd,
  input  logic [LW-1:0] c0,
  input  logic [LW-1:0] c1,
  output logic [LW-1:0] s0,
  output logic [LW-1:0] s1,
  output logic [LW-1:0] nc0,
  output logic [LW-1:0] nc1
);

  logic [LW-1:0] x0, x1, y0, y1, z0, z1, cm0, cm1, am0, am1;

  // On the first slice the carry-in is zero, so the carry is simply a AND b.
  assign cm0 = first ? '0 : c0;
  assign cm1 = first ? '0 : c1;
  assign am0 = first ? '0 : a0;
  assign am1 = first ? '0 : a1;

  assign x0 = first ? a0 : (a0 ^ b0);
  assign x1 = first ? a1 : (a1 ^ b1);
  assign y0 = first ? b0 : (a0 ^ c0);
  assign y1 = first ? b1 : (a1 ^ c1);

  // Each output share sees the other input share only through the fresh mask.
  assign z0 = (x0 & y0) ^ (x0 & (y1 ^ rnd)) ^ (rnd & ~x0);
  assign z1 = (x1 & y1) ^ (x1 & (y0 ^ rnd)) ^ (rnd & ~x1);

  assign s0  = a0 ^ b0 ^ cm0;
  assign s1  = a1 ^ b1 ^ cm1;
  assign nc0 = z0 ^ am0;
  assign nc1 = z1 ^ am1;

endmodule

// ----- src/mba_fifo.sv -----
// Small result queue that takes up to two words per cycle and gives one.
// Imports mba_pkg, though it uses none of its constants.
module mba_fifo import mba_pkg::*; #(
  parameter int unsigned WIDTH = 65,
  parameter int unsigned DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push0,
  input  logic [WIDTH-1:0]             data0,
  input  logic                         push1,
  input  logic [WIDTH-1:0]             data1,
  input  logic                         pop,
  output logic                         head_valid,
  output logic [WIDTH-1:0]             head_data,
  output logic [$clog2(DEPTH+1)-1:0]   free
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt, wr_ptr1;
  logic [CNT_W-1:0] count_r, count_nxt, n_push;
  logic             do_pop;

  assign head_valid = (count_r != '0);
  assign head_data  = mem_r[rd_ptr_r];
  assign free       = CNT_W'(DEPTH) - count_r;
  assign do_pop     = pop && head_valid;
  assign wr_ptr1    = wr_ptr_r + PTR_W'(1);

  always_comb begin
    n_push = CNT_W'(push0) + CNT_W'(push0 && push1);
    wr_ptr_nxt = wr_ptr_r + PTR_W'(n_push);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(do_pop);
    count_nxt  = count_r + n_push - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push0) begin
      mem_r[wr_ptr_r] <= data0;
    end
    if (push0 && push1) begin
      mem_r[wr_ptr1] <= data1;
    end
  end

endmodule

// ----- src/masked_bitsliced_adder.sv -----
// Top level of the two-share Boolean-masked bitsliced ripple-carry adder.
// Depends on mba_pkg, mba_slice and mba_fifo.
//
// Each input word is one bit slice of two masked addends, least significant
// slice first, with one fresh random word for the masked AND that forms the
// carry. A word is registered, processed combinationally against the stored
// masked carry and written into a four-entry result queue, so the block takes
// one word per clock; the result can leave the queue from the cycle after it
// is written. The final slice of an addition gives two result words when the
// carry-out is enabled, which the queue absorbs; the input stalls only while
// fewer than two queue entries are free. num_bits selects the slices per
// addition (0 acts as 1, values above MAX_SLICES act as MAX_SLICES) and must
// be written only while the block is idle.
module masked_bitsliced_adder import mba_pkg::*; #(
  parameter int unsigned LANE_BITS  = 32,
  parameter int unsigned MAX_SLICES = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [FIELD_W-1:0]    in_a_share0,
  input  logic [FIELD_W-1:0]    in_a_share1,
  input  logic [FIELD_W-1:0]    in_b_share0,
  input  logic [FIELD_W-1:0]    in_b_share1,
  input  logic [FIELD_W-1:0]    in_rand_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [FIELD_W-1:0]    out_sum_share0,
  output logic [FIELD_W-1:0]    out_sum_share1,
  output logic                  out_last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned LW     = LANE_BITS;
  localparam int unsigned IDX_W  = $clog2(MAX_SLICES);
  localparam int unsigned CMP_W  = 6;
  localparam int unsigned DEPTH  = 4;
  localparam int unsigned ENT_W  = 2 * FIELD_W + 1;
  localparam int unsigned FREE_W = $clog2(DEPTH + 1);

  // Configuration registers.
  logic [NUM_BITS_W-1:0] num_bits_r;
  logic                  cout_ena_r;

  // Input register.
  logic          s1_valid_r;
  logic [LW-1:0] a0_r, a1_r, b0_r, b1_r, rnd_r;

  // Running masked carry and slice position.
  logic [LW-1:0]    carry0_r, carry1_r;
  logic [IDX_W-1:0] idx_r;

  logic              in_acc, adv, final_slice;
  logic [CMP_W-1:0]  n_eff;
  logic [LW-1:0]     s0, s1, nc0, nc1;
  logic [FREE_W-1:0] q_free;
  logic              push1;
  logic [ENT_W-1:0]  ent0, ent1, head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_bits_r <= NUM_BITS_W'(13);
      cout_ena_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_NUM_BITS:      num_bits_r <= cfg_data[NUM_BITS_W-1:0];
        CFG_CARRY_OUT_ENA: cout_ena_r <= cfg_data[0];
        default:           ;
      endcase
    end
  end

  // The queue must hold the two words a final slice may produce.
  assign adv      = s1_valid_r && (q_free >= FREE_W'(MAX_RESULTS));
  assign in_stall = s1_valid_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a0_r  <= LW'(in_a_share0);
      a1_r  <= LW'(in_a_share1);
      b0_r  <= LW'(in_b_share0);
      b1_r  <= LW'(in_b_share1);
      rnd_r <= LW'(in_rand_word);
    end
  end

  always_comb begin
    if (num_bits_r == '0) begin
      n_eff = CMP_W'(1);
    end else if (CMP_W'(num_bits_r) > CMP_W'(MAX_SLICES)) begin
      n_eff = CMP_W'(MAX_SLICES);
    end else begin
      n_eff = CMP_W'(num_bits_r);
    end
  end

  // A slice at or past the last index ends the addition, even after a width change.
  assign final_slice = (CMP_W'(idx_r) >= (n_eff - CMP_W'(1)));

  mba_slice #(
    .LW (LW)
  ) u_slice (
    .first (idx_r == '0),
    .a0    (a0_r),
    .a1    (a1_r),
    .b0    (b0_r),
    .b1    (b1_r),
    .rnd   (rnd_r),
    .c0    (carry0_r),
    .c1    (carry1_r),
    .s0    (s0),
    .s1    (s1),
    .nc0   (nc0),
    .nc1   (nc1)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carry0_r <= '0;
      carry1_r <= '0;
      idx_r    <= '0;
    end else if (adv) begin
      if (final_slice) begin
        carry0_r <= '0;
        carry1_r <= '0;
        idx_r    <= '0;
      end else begin
        carry0_r <= nc0;
        carry1_r <= nc1;
        idx_r    <= idx_r + IDX_W'(1);
      end
    end
  end

  assign push1 = adv && final_slice && cout_ena_r;
  assign ent0  = {final_slice && !cout_ena_r, FIELD_W'(s1), FIELD_W'(s0)};
  assign ent1  = {1'b1, FIELD_W'(nc1), FIELD_W'(nc0)};

  mba_fifo #(
    .WIDTH (ENT_W),
    .DEPTH (DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push0      (adv),
    .data0      (ent0),
    .push1      (push1),
    .data1      (ent1),
    .pop        (!out_stall),
    .head_valid (out_valid),
    .head_data  (head),
    .free       (q_free)
  );

  assign out_sum_share0 = head[FIELD_W-1:0];
  assign out_sum_share1 = head[2*FIELD_W-1:FIELD_W];
  assign out_last       = head[ENT_W-1];

  // An empty input register never holds off the sender.
  assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> !in_stall)
    else $error("input stalled with empty input register");

  // The final slice always leaves a cleared carry and index behind.
  assert property (@(posedge clk) disable iff (!rst_n)
    (adv && final_slice) |=> (carry0_r == '0 && carry1_r == '0 && idx_r == '0))
    else $error("carry state not cleared after final slice");

  // A second word is only produced for a final slice with carry-out enabled.
  assert property (@(posedge clk) disable iff (!rst_n)
    push1 |-> (final_slice && cout_ena_r && adv))
    else $error("carry-out word pushed outside a final slice");

  // A slice that advances never finds the queue short of room.
  assert property (@(posedge clk) disable iff (!rst_n)
    adv |-> (q_free >= FREE_W'(MAX_RESULTS)))
    else $error("result queue overflow");

endmodule
